// ----- design/accel_tilt_quaternion_assert.svh -----
// assertion macros shared by the accel tilt quaternion checker
// no dependencies; expects clk and arst_n in the including scope
`ifndef ACCEL_TILT_QUATERNION_ASSERT_SVH
`define ACCEL_TILT_QUATERNION_ASSERT_SVH
// same-cycle implication
`define ATQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("atq check failed");
// next-cycle implication
`define ATQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("atq check failed");
`endif

// ----- design/atq_pkg.sv -----
// shared types and constants of the accel tilt quaternion pipeline
// no dependencies
package atq_pkg;
	localparam int QUO_W     = 61;
	localparam int ROOT_IN_W = 62;
	localparam int ROOT_W    = ROOT_IN_W / 2;
	localparam logic [ROOT_W-1:0] ONE_Q30 = ROOT_W'(1) << 30;
	localparam logic [15:0] Q15_MAX = 16'h7fff;
	localparam logic [15:0] Q15_MIN_MAG = 16'h8000;

	typedef struct packed {
		logic zero_s;
		logic zero_p;
		logic az_pos;
		logic ax_neg;
		logic ay_pos;
	} atq_flags_t;

	localparam int FLAGS_W = $bits(atq_flags_t);

	// saturating signed q1.15 from a magnitude and a sign
	function automatic logic [15:0] sat_q15(input logic [17:0] mag, input logic neg);
		logic [15:0] res;
		if (neg) begin
			if (mag > 18'(Q15_MIN_MAG)) res = Q15_MIN_MAG;
			else res = 16'(18'd0 - mag);
		end else begin
			if (mag > 18'(Q15_MAX)) res = Q15_MAX;
			else res = mag[15:0];
		end
		return res;
	endfunction
endpackage

// ----- design/atq_frac_div.sv -----
// pipelined restoring divider, floor(num * 2^60 / den), one quotient bit per stage
// depends on atq_pkg
module atq_frac_div #(
	parameter int DW     = 34,
	parameter int LANES  = 3,
	parameter int SIDE_W = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [SIDE_W-1:0] in_side,
	input  logic [LANES-1:0][DW-1:0] num,
	input  logic [LANES-1:0][DW-1:0] den,
	output logic out_valid,
	output logic [SIDE_W-1:0] out_side,
	output logic [LANES-1:0][atq_pkg::QUO_W-1:0] quo
);
	import atq_pkg::*;

	logic [QUO_W:0] vld_s;
	logic [SIDE_W-1:0] side_s [0:QUO_W];
	logic [LANES-1:0][DW-1:0] rem_s [0:QUO_W];
	logic [LANES-1:0][DW-1:0] den_s [0:QUO_W];
	logic [LANES-1:0][QUO_W-1:0] quo_s [0:QUO_W];

	assign vld_s[0]  = in_valid;
	assign side_s[0] = in_side;
	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [LANES-1:0][DW-1:0] rem_n;
		logic [LANES-1:0][QUO_W-1:0] quo_n;

		always_comb begin
			logic [DW:0] r;
			for (int l = 0; l < LANES; l++) begin
				// first step compares without a shift
				r = (k == 0) ? {1'b0, rem_s[k][l]} : {rem_s[k][l], 1'b0};
				if (r >= {1'b0, den_s[k][l]}) begin
					rem_n[l] = DW'(r - {1'b0, den_s[k][l]});
					quo_n[l] = {quo_s[k][l][QUO_W-2:0], 1'b1};
				end else begin
					rem_n[l] = r[DW-1:0];
					quo_n[l] = {quo_s[k][l][QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				rem_s[k+1]  <= rem_n;
				den_s[k+1]  <= den_s[k];
				quo_s[k+1]  <= quo_n;
			end
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign out_side  = side_s[QUO_W];
	assign quo       = quo_s[QUO_W];
endmodule

// ----- design/atq_isqrt.sv -----
// pipelined floor square root, one result bit per stage
// depends on atq_pkg
module atq_isqrt #(
	parameter int LANES  = 3,
	parameter int SIDE_W = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [SIDE_W-1:0] in_side,
	input  logic [LANES-1:0][atq_pkg::ROOT_IN_W-1:0] rad,
	output logic out_valid,
	output logic [SIDE_W-1:0] out_side,
	output logic [LANES-1:0][atq_pkg::ROOT_W-1:0] root
);
	import atq_pkg::*;

	localparam int STEPS = ROOT_IN_W / 2;

	logic [STEPS:0] vld_s;
	logic [SIDE_W-1:0] side_s [0:STEPS];
	logic [LANES-1:0][ROOT_IN_W-1:0] rem_s [0:STEPS];
	logic [LANES-1:0][ROOT_IN_W-1:0] res_s [0:STEPS];

	assign vld_s[0]  = in_valid;
	assign side_s[0] = in_side;
	assign rem_s[0]  = rad;
	assign res_s[0]  = '0;

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam logic [ROOT_IN_W:0] BITV = (ROOT_IN_W+1)'(1) << (ROOT_IN_W - 2 - 2 * j);
		logic [LANES-1:0][ROOT_IN_W-1:0] rem_n;
		logic [LANES-1:0][ROOT_IN_W-1:0] res_n;

		always_comb begin
			logic [ROOT_IN_W:0] trial;
			for (int l = 0; l < LANES; l++) begin
				trial = {1'b0, res_s[j][l]} + BITV;
				if ({1'b0, rem_s[j][l]} >= trial) begin
					rem_n[l] = ROOT_IN_W'({1'b0, rem_s[j][l]} - trial);
					res_n[l] = ROOT_IN_W'({2'b0, res_s[j][l][ROOT_IN_W-1:1]} + BITV);
				end else begin
					rem_n[l] = rem_s[j][l];
					res_n[l] = {1'b0, res_s[j][l][ROOT_IN_W-1:1]};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j+1] <= side_s[j];
				rem_s[j+1]  <= rem_n;
				res_s[j+1]  <= res_n;
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign out_side  = side_s[STEPS];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign root[l] = res_s[STEPS][l][ROOT_W-1:0];
	end
endmodule

// ----- design/accel_tilt_quaternion.sv -----
// accel tilt quaternion top: sample -> unit quaternion turning it onto (0,0,-1)
// stages: squares, sums, 61 divider stages, 31 root stages, clamp, 31 root
// stages, multiply, round; one transaction per cycle unless the output stalls
// a stall on the result side freezes every stage together; nothing is lost
// arst_n clears all valid bits at once; payload registers are not reset
module accel_tilt_quaternion #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // accel_x, accel_y, accel_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // quat_x, quat_y, quat_z, quat_w(15), zero pad
	output logic [0:0]  m_axis_tuser   // invalid_sample
);
	import atq_pkg::*;

	localparam int EXT_W = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
	localparam int SQ_W  = 2 * SAMPLE_BITS;
	localparam int DW    = SQ_W + 2;
	localparam int SIDE2_W = FLAGS_W + 2 * ROOT_W;
	localparam int LANES_DIV = 3;

	// whole pipe advances unless the output register holds an untaken result
	logic en;
	logic vld_s5;
	assign en            = !vld_s5 || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: sign extend the low SAMPLE_BITS bits and square
	logic [EXT_W-1:0] raw_x, raw_y, raw_z;
	logic signed [SAMPLE_BITS-1:0] ax, ay, az;
	logic signed [SQ_W-1:0] prod_x, prod_y, prod_z;
	assign raw_x = EXT_W'(s_axis_tdata[15:0]);
	assign raw_y = EXT_W'(s_axis_tdata[31:16]);
	assign raw_z = EXT_W'(s_axis_tdata[47:32]);
	assign ax = raw_x[SAMPLE_BITS-1:0];
	assign ay = raw_y[SAMPLE_BITS-1:0];
	assign az = raw_z[SAMPLE_BITS-1:0];
	assign prod_x = ax * ax;
	assign prod_y = ay * ay;
	assign prod_z = az * az;

	logic vld_s1;
	logic [SQ_W-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic az_pos_s1, ax_neg_s1, ay_pos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1    <= $unsigned(prod_x);
			sqy_s1    <= $unsigned(prod_y);
			sqz_s1    <= $unsigned(prod_z);
			az_pos_s1 <= !az[SAMPLE_BITS-1] && (az != '0);
			ax_neg_s1 <= ax[SAMPLE_BITS-1];
			ay_pos_s1 <= !ay[SAMPLE_BITS-1] && (ay != '0);
		end
	end

	// stage 2: planar and full squared lengths, special case flags
	logic [DW-1:0] p_sum, s_sum;
	assign p_sum = DW'(sqx_s1) + DW'(sqy_s1);
	assign s_sum = p_sum + DW'(sqz_s1);

	logic vld_s2;
	logic [LANES_DIV-1:0][DW-1:0] num_s2, den_s2;
	atq_flags_t flags_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// lane 0: cos magnitude, lane 1: x share, lane 2: y share
			num_s2[0] <= DW'(sqz_s1);
			den_s2[0] <= s_sum;
			num_s2[1] <= DW'(sqx_s1);
			den_s2[1] <= p_sum;
			num_s2[2] <= DW'(sqy_s1);
			den_s2[2] <= p_sum;
			flags_s2.zero_s <= (s_sum == '0);
			flags_s2.zero_p <= (p_sum == '0);
			flags_s2.az_pos <= az_pos_s1;
			flags_s2.ax_neg <= ax_neg_s1;
			flags_s2.ay_pos <= ay_pos_s1;
		end
	end

	// fractional ratios in q1.60
	logic div_vld;
	logic [FLAGS_W-1:0] div_side;
	logic [LANES_DIV-1:0][QUO_W-1:0] div_quo;

	atq_frac_div #(
		.DW(DW),
		.LANES(LANES_DIV),
		.SIDE_W(FLAGS_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s2),
		.in_side(flags_s2),
		.num(num_s2),
		.den(den_s2),
		.out_valid(div_vld),
		.out_side(div_side),
		.quo(div_quo)
	);

	// square roots give q1.30 magnitudes of cos theta, x and y axis parts
	logic [LANES_DIV-1:0][ROOT_IN_W-1:0] rad1;
	for (genvar l = 0; l < LANES_DIV; l++) begin : g_rad1
		assign rad1[l] = ROOT_IN_W'(div_quo[l]);
	end

	logic rt1_vld;
	logic [FLAGS_W-1:0] rt1_side;
	logic [LANES_DIV-1:0][ROOT_W-1:0] rt1_root;

	atq_isqrt #(
		.LANES(LANES_DIV),
		.SIDE_W(FLAGS_W)
	) u_root_ratio (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(div_vld),
		.in_side(div_side),
		.rad(rad1),
		.out_valid(rt1_vld),
		.out_side(rt1_side),
		.root(rt1_root)
	);

	// stage 3: clamp cos, form half-angle radicands (1 +/- c) * 2^59
	atq_flags_t rt1_flags;
	logic [ROOT_W-1:0] cmag;
	logic [ROOT_W:0] one_plus, one_minus;
	assign rt1_flags = rt1_side;
	assign cmag      = (rt1_root[0] > ONE_Q30) ? ONE_Q30 : rt1_root[0];
	assign one_plus  = {1'b0, ONE_Q30} + {1'b0, cmag};
	assign one_minus = {1'b0, ONE_Q30} - {1'b0, cmag};

	logic vld_s3;
	logic [1:0][ROOT_IN_W-1:0] rad_s3;
	logic [SIDE2_W-1:0] side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= rt1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// lane 0: cos(theta/2), lane 1: sin(theta/2); c is negative when az > 0
			if (rt1_flags.az_pos) begin
				rad_s3[0] <= ROOT_IN_W'({one_minus, 29'd0});
				rad_s3[1] <= ROOT_IN_W'({one_plus, 29'd0});
			end else begin
				rad_s3[0] <= ROOT_IN_W'({one_plus, 29'd0});
				rad_s3[1] <= ROOT_IN_W'({one_minus, 29'd0});
			end
			side_s3 <= {rt1_side, rt1_root[1], rt1_root[2]};
		end
	end

	logic rt2_vld;
	logic [SIDE2_W-1:0] rt2_side;
	logic [1:0][ROOT_W-1:0] rt2_root;

	atq_isqrt #(
		.LANES(2),
		.SIDE_W(SIDE2_W)
	) u_root_half (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s3),
		.in_side(side_s3),
		.rad(rad_s3),
		.out_valid(rt2_vld),
		.out_side(rt2_side),
		.root(rt2_root)
	);

	// stage 4: scale the unit axis by sin(theta/2)
	atq_flags_t rt2_flags;
	logic [ROOT_W-1:0] mx_rt, my_rt;
	assign {rt2_flags, mx_rt, my_rt} = rt2_side;

	logic vld_s4;
	logic [2*ROOT_W-1:0] mulx_s4, muly_s4;
	logic [ROOT_W-1:0] w30_s4;
	atq_flags_t flags_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= rt2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mulx_s4  <= my_rt * rt2_root[1];
			muly_s4  <= mx_rt * rt2_root[1];
			w30_s4   <= rt2_root[0];
			flags_s4 <= rt2_flags;
		end
	end

	// stage 5: round to q1.15, saturate, special cases; output register
	logic [2*ROOT_W:0] rnd_x, rnd_y;
	logic [ROOT_W:0] rnd_w;
	logic [15:0] qx_n, qy_n, qw_full;
	logic [14:0] qw_n;
	assign rnd_x   = {1'b0, mulx_s4} + ((2*ROOT_W+1)'(1) << 44);
	assign rnd_y   = {1'b0, muly_s4} + ((2*ROOT_W+1)'(1) << 44);
	assign rnd_w   = {1'b0, w30_s4} + ((ROOT_W+1)'(1) << 14);
	assign qw_full = 16'(rnd_w >> 15);

	always_comb begin
		qx_n = sat_q15(rnd_x[62:45], flags_s4.ay_pos);
		qy_n = sat_q15(rnd_y[62:45], flags_s4.ax_neg);
		qw_n = (qw_full > Q15_MAX) ? Q15_MAX[14:0] : qw_full[14:0];
		if (flags_s4.zero_s) begin
			qx_n = '0;
			qy_n = '0;
			qw_n = Q15_MAX[14:0];
		end else if (flags_s4.zero_p) begin
			// on the axis: identity when aligned, half turn about x when opposite
			qy_n = '0;
			if (flags_s4.az_pos) begin
				qx_n = Q15_MAX;
				qw_n = '0;
			end else begin
				qx_n = '0;
				qw_n = Q15_MAX[14:0];
			end
		end
	end

	logic [15:0] qx_s5, qy_s5;
	logic [14:0] qw_s5;
	logic inv_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s5  <= qx_n;
			qy_s5  <= qy_n;
			qw_s5  <= qw_n;
			inv_s5 <= flags_s4.zero_s;
		end
	end

	assign m_axis_tvalid   = vld_s5;
	assign m_axis_tdata    = {1'b0, qw_s5, 16'd0, qy_s5, qx_s5};
	assign m_axis_tuser[0] = inv_s5;
endmodule

// ----- design/atq_checker.sv -----
// port-level checks for accel_tilt_quaternion, bound to the top level
// depends on accel_tilt_quaternion_assert.svh
`include "accel_tilt_quaternion_assert.svh"
module atq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [47:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);
	// stalled result stays offered
	`ATQ_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	// stalled result keeps its payload
	`ATQ_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))
	// result flagged invalid (zero sample) carries the identity
	`ATQ_ASSERT_IMP(a_invalid_identity, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == {1'b0, 15'h7fff, 48'd0})
	// input side only stalls while a result waits
	`ATQ_ASSERT_IMP(a_ready_link, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
endmodule

bind accel_tilt_quaternion atq_checker u_atq_checker (.*);
